FILE: rtl/core/stt_pkg.sv
// Package of types, constants and byte codes shared by the tokenizer modules.
`timescale 1ns / 1ps
package stt_pkg;

  // Sizes
  localparam int MAX_NEST    = 255;
  localparam int NEST_W      = $clog2(MAX_NEST + 1);
  localparam int MAX_RES     = 6;
  localparam int RES_IDX_W   = $clog2(MAX_RES);
  localparam int RES_CNT_W   = $clog2(MAX_RES + 1);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_REGS    = 4;
  localparam int CFG_IDX_W   = $clog2(CFG_REGS);
  localparam int PADDR_W     = CFG_IDX_W + 3;
  localparam logic [31:0] SAT32 = 32'hFFFF_FFFF;

  // Result kinds
  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_CHAR    = 2'd1;
  localparam logic [1:0] KIND_END     = 2'd2;
  localparam logic [1:0] KIND_UNTERM  = 2'd3;

  // Byte codes
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_BSLASH = 8'h5C;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_SLASH,
    MODE_LINE,
    MODE_BLK,
    MODE_BLK_SLASH,
    MODE_BLK_STAR,
    MODE_WORD,
    MODE_STR,
    MODE_STR_ESC
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       end_of_source;
  } src_word_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  tok_char;
    logic        is_quoted;
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] offset;
    logic        last_of_run;
  } tok_word_t;

  // One pending result, its position taken from one of two start records
  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] chr;
    logic       quoted;
    logic       use_cur;
  } item_t;

  typedef struct packed {
    logic [31:0] line;
    logic [31:0] column;
    logic [31:0] offset;
  } pos_t;

  // All results caused by one source byte
  typedef struct packed {
    logic [RES_CNT_W-1:0]     n;
    item_t [MAX_RES-1:0]      items;
    pos_t                     pos_slash;
    pos_t                     pos_cur;
  } job_t;

endpackage

FILE: rtl/core/stt_front.sv
// Front end: scanner state machine that turns each source byte into a job of results.
`timescale 1ns / 1ps
module stt_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              src_valid,
  output logic              src_stall,
  input  stt_pkg::src_word_t src_word,
  input  logic [255:0]      alone_map,
  input  logic              full,
  output logic              push,
  output stt_pkg::job_t     job
);

  stt_pkg::scan_mode_t          mode, mode_next;
  logic [7:0]                   quote_byte, quote_byte_next;
  logic [stt_pkg::NEST_W-1:0]   nest_depth, nest_depth_next;
  logic [31:0]                  line_count, line_count_next;
  logic [31:0]                  byte_count, byte_count_next;
  logic                         nl_seen, nl_seen_next;
  logic [31:0]                  nl_pos, nl_pos_next;
  logic [31:0]                  slash_off, slash_off_next;

  logic                         accept;
  logic [7:0]                   c;
  logic                         c_alone;
  logic                         c_delim;
  logic                         again;
  stt_pkg::job_t                j;

  // Append one result to a job
  function automatic stt_pkg::job_t push_item(stt_pkg::job_t ji, logic [1:0] k,
                                             logic [7:0] chr, logic q, logic cur);
    stt_pkg::job_t r;
    r = ji;
    if (r.n < stt_pkg::RES_CNT_W'(stt_pkg::MAX_RES)) begin
      r.items[r.n[stt_pkg::RES_IDX_W-1:0]] = '{kind: k, chr: chr, quoted: q, use_cur: cur};
      r.n = r.n + 1'b1;
    end
    return r;
  endfunction

  // Start position for a token at offset o: column counts from the latest line break
  function automatic stt_pkg::pos_t make_pos(logic [31:0] o, logic [31:0] ln,
                                            logic seen, logic [31:0] nlp);
    stt_pkg::pos_t p;
    logic [32:0]   d;
    p.line   = ln;
    p.offset = o;
    d        = {1'b0, o} + 33'd1;
    if (!seen) begin
      p.column = d[32] ? stt_pkg::SAT32 : d[31:0];
    end else if (o > nlp) begin
      p.column = o - nlp;
    end else begin
      p.column = 32'd1;
    end
    return p;
  endfunction

  assign accept    = src_valid && !full;
  assign src_stall = full;
  assign c         = src_word.ch;
  assign c_alone   = alone_map[c];
  assign push      = accept && (j.n != '0);
  assign job       = j;

  always_comb begin
    c_delim = c inside {stt_pkg::CH_DQUOTE, stt_pkg::CH_SQUOTE, stt_pkg::CH_SPACE,
                        stt_pkg::CH_TAB, stt_pkg::CH_LF, stt_pkg::CH_CR,
                        stt_pkg::CH_BS, stt_pkg::CH_FF, stt_pkg::CH_NUL};
  end

  // Step the scanner over one byte; a byte may be rescanned in a following mode
  always_comb begin
    j                 = '0;
    j.pos_slash       = make_pos(slash_off, line_count, nl_seen, nl_pos);
    j.pos_cur         = make_pos(byte_count, line_count, nl_seen, nl_pos);
    mode_next         = mode;
    quote_byte_next   = quote_byte;
    nest_depth_next   = nest_depth;
    slash_off_next    = slash_off;
    line_count_next   = line_count;
    byte_count_next   = byte_count;
    nl_seen_next      = nl_seen;
    nl_pos_next       = nl_pos;
    again             = 1'b1;

    for (int pass = 0; pass < 3; pass++) begin
      if (again) begin
        again = 1'b0;
        case (mode_next)
          stt_pkg::MODE_IDLE: begin
            if (c <= stt_pkg::CH_SPACE) begin
              mode_next = stt_pkg::MODE_IDLE;
            end else if (c == stt_pkg::CH_SLASH) begin
              mode_next      = stt_pkg::MODE_SLASH;
              slash_off_next = byte_count;
            end else if (c == stt_pkg::CH_DQUOTE || c == stt_pkg::CH_SQUOTE) begin
              j               = push_item(j, stt_pkg::KIND_START, 8'd0, 1'b1, 1'b1);
              quote_byte_next = c;
              mode_next       = stt_pkg::MODE_STR;
            end else begin
              j = push_item(j, stt_pkg::KIND_START, 8'd0, 1'b0, 1'b1);
              j = push_item(j, stt_pkg::KIND_CHAR, c, 1'b0, 1'b0);
              if (c_alone) begin
                j = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
              end else begin
                mode_next = stt_pkg::MODE_WORD;
              end
            end
          end
          stt_pkg::MODE_SLASH: begin
            if (c == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_LINE;
            end else if (c == stt_pkg::CH_STAR) begin
              mode_next       = stt_pkg::MODE_BLK;
              nest_depth_next = stt_pkg::NEST_W'(1);
            end else begin
              // lone slash becomes a token, then rescan this byte
              j = push_item(j, stt_pkg::KIND_START, 8'd0, 1'b0, 1'b0);
              j = push_item(j, stt_pkg::KIND_CHAR, stt_pkg::CH_SLASH, 1'b0, 1'b0);
              if (alone_map[stt_pkg::CH_SLASH]) begin
                j         = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
                mode_next = stt_pkg::MODE_IDLE;
              end else begin
                mode_next = stt_pkg::MODE_WORD;
              end
              again = 1'b1;
            end
          end
          stt_pkg::MODE_LINE: begin
            if (c == stt_pkg::CH_LF) begin
              mode_next = stt_pkg::MODE_IDLE;
            end
          end
          stt_pkg::MODE_BLK: begin
            if (c == stt_pkg::CH_SLASH) begin
              mode_next = stt_pkg::MODE_BLK_SLASH;
            end else if (c == stt_pkg::CH_STAR) begin
              mode_next = stt_pkg::MODE_BLK_STAR;
            end
          end
          stt_pkg::MODE_BLK_SLASH: begin
            mode_next = stt_pkg::MODE_BLK;
            if (c == stt_pkg::CH_STAR) begin
              if (nest_depth_next < stt_pkg::NEST_W'(stt_pkg::MAX_NEST)) begin
                nest_depth_next = nest_depth_next + 1'b1;
              end
            end else begin
              again = 1'b1;
            end
          end
          stt_pkg::MODE_BLK_STAR: begin
            mode_next = stt_pkg::MODE_BLK;
            if (c == stt_pkg::CH_SLASH) begin
              if (nest_depth_next != '0) begin
                nest_depth_next = nest_depth_next - 1'b1;
              end
              if (nest_depth_next == '0) begin
                mode_next = stt_pkg::MODE_IDLE;
              end
            end else begin
              again = 1'b1;
            end
          end
          stt_pkg::MODE_WORD: begin
            if (c_alone || c_delim) begin
              j         = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
              mode_next = stt_pkg::MODE_IDLE;
              again     = 1'b1;
            end else begin
              j = push_item(j, stt_pkg::KIND_CHAR, c, 1'b0, 1'b0);
            end
          end
          stt_pkg::MODE_STR: begin
            if (c == quote_byte_next) begin
              j         = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b1, 1'b0);
              mode_next = stt_pkg::MODE_IDLE;
            end else if (c == stt_pkg::CH_BSLASH) begin
              mode_next = stt_pkg::MODE_STR_ESC;
            end else begin
              j = push_item(j, stt_pkg::KIND_CHAR, c, 1'b1, 1'b0);
            end
          end
          stt_pkg::MODE_STR_ESC: begin
            j         = push_item(j, stt_pkg::KIND_CHAR, c, 1'b1, 1'b0);
            mode_next = stt_pkg::MODE_STR;
          end
          default: begin
            mode_next = stt_pkg::MODE_IDLE;
          end
        endcase
      end
    end

    if (src_word.end_of_source) begin
      // close whatever is open, then return to the start of a new text
      case (mode_next)
        stt_pkg::MODE_SLASH: begin
          j = push_item(j, stt_pkg::KIND_START, 8'd0, 1'b0, 1'b1);
          j = push_item(j, stt_pkg::KIND_CHAR, stt_pkg::CH_SLASH, 1'b0, 1'b0);
          j = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
        end
        stt_pkg::MODE_WORD: begin
          j = push_item(j, stt_pkg::KIND_END, 8'd0, 1'b0, 1'b0);
        end
        stt_pkg::MODE_STR, stt_pkg::MODE_STR_ESC: begin
          j = push_item(j, stt_pkg::KIND_UNTERM, 8'd0, 1'b1, 1'b0);
        end
        default: begin
          j = j;
        end
      endcase
      mode_next       = stt_pkg::MODE_IDLE;
      quote_byte_next = 8'd0;
      nest_depth_next = '0;
      line_count_next = 32'd1;
      byte_count_next = 32'd0;
      nl_seen_next    = 1'b0;
      nl_pos_next     = 32'd0;
      slash_off_next  = 32'd0;
    end else begin
      if (c == stt_pkg::CH_LF && line_count != stt_pkg::SAT32) begin
        line_count_next = line_count + 32'd1;
      end
      if (c == stt_pkg::CH_LF || c == stt_pkg::CH_CR) begin
        nl_seen_next = 1'b1;
        nl_pos_next  = byte_count;
      end
      if (byte_count != stt_pkg::SAT32) begin
        byte_count_next = byte_count + 32'd1;
      end
    end
  end

  // Advance the scanner state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= stt_pkg::MODE_IDLE;
      quote_byte <= 8'd0;
      nest_depth <= '0;
      line_count <= 32'd1;
      byte_count <= 32'd0;
      nl_seen    <= 1'b0;
      nl_pos     <= 32'd0;
      slash_off  <= 32'd0;
    end else if (accept) begin
      mode       <= mode_next;
      quote_byte <= quote_byte_next;
      nest_depth <= nest_depth_next;
      line_count <= line_count_next;
      byte_count <= byte_count_next;
      nl_seen    <= nl_seen_next;
      nl_pos     <= nl_pos_next;
      slash_off  <= slash_off_next;
    end
  end

endmodule

FILE: rtl/core/stt_queue.sv
// Short job queue between the scanner front end and the result back end.
`timescale 1ns / 1ps
module stt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  stt_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output stt_pkg::job_t head_job
);

  stt_pkg::job_t               mem [stt_pkg::QUEUE_DEPTH];
  logic [stt_pkg::QPTR_W-1:0]  wr_ptr;
  logic [stt_pkg::QPTR_W-1:0]  rd_ptr;
  logic [stt_pkg::QCNT_W-1:0]  count;

  assign full       = (count == stt_pkg::QCNT_W'(stt_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = mem[rd_ptr];

  // Store jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_job;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: rtl/core/stt_back.sv
// Back end: unpacks each job into result words through a registered output stage.
`timescale 1ns / 1ps
module stt_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  stt_pkg::job_t      head_job,
  output logic               pop,
  output logic               tok_valid,
  input  logic               tok_stall,
  output stt_pkg::tok_word_t tok_word
);

  logic [stt_pkg::RES_IDX_W-1:0] idx;
  logic                          out_valid;
  stt_pkg::tok_word_t            out_word;
  stt_pkg::tok_word_t            word_next;
  stt_pkg::item_t                it;
  stt_pkg::pos_t                 pos;
  logic                          load;
  logic                          last;

  assign load = head_valid && (!out_valid || !tok_stall);
  assign it   = head_job.items[idx];
  assign pos  = it.use_cur ? head_job.pos_cur : head_job.pos_slash;
  assign last = (stt_pkg::RES_CNT_W'(idx) + stt_pkg::RES_CNT_W'(1)) == head_job.n;
  assign pop  = load && last;

  assign tok_valid = out_valid;
  assign tok_word  = out_word;

  // Format the current item; fields that do not apply read as zero
  always_comb begin
    word_next             = '0;
    word_next.kind        = it.kind;
    word_next.is_quoted   = it.quoted;
    word_next.last_of_run = last;
    if (it.kind == stt_pkg::KIND_CHAR) begin
      word_next.tok_char = it.chr;
    end
    if (it.kind == stt_pkg::KIND_START) begin
      word_next.line   = pos.line;
      word_next.column = pos.column;
      word_next.offset = pos.offset;
    end
  end

  // Hold the output word until taken; step through the job's items
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        idx       <= last ? '0 : idx + 1'b1;
      end else if (!tok_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_word <= word_next;
    end
  end

endmodule

FILE: rtl/core/source_text_tokenizer_core.sv
// Top level: register port, scanner front end, job queue and result back end.
// The first result of a byte passes through the job queue and then the registered output stage.
// Bytes are taken one a cycle unless the queue is full; results leave one a cycle unless
// tok_stall holds them, and a four-job queue absorbs bursts from bytes with many results.
// Reset clears the scanner to the start of a text, the queue and the output stage,
// and sets all four single-character bitmaps to zero.
`timescale 1ns / 1ps
module source_text_tokenizer_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        src_valid,
  output logic                        src_stall,
  input  stt_pkg::src_word_t          src_word,
  output logic                        tok_valid,
  input  logic                        tok_stall,
  output stt_pkg::tok_word_t          tok_word,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [stt_pkg::PADDR_W-1:0] paddr,
  input  logic [63:0]                 pwdata,
  output logic [63:0]                 prdata,
  output logic                        pready
);

  logic [63:0]   alone_set [stt_pkg::CFG_REGS];
  logic [255:0]  alone_map;
  logic          q_full;
  logic          q_push;
  stt_pkg::job_t q_push_job;
  logic          q_pop;
  logic          q_head_valid;
  stt_pkg::job_t q_head_job;
  logic [stt_pkg::CFG_IDX_W-1:0] reg_idx;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[stt_pkg::PADDR_W-1:3];
  assign prdata    = alone_set[reg_idx];
  assign alone_map = {alone_set[3], alone_set[2], alone_set[1], alone_set[0]};

  // Write the single-character bitmaps
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < stt_pkg::CFG_REGS; i++) begin
        alone_set[i] <= 64'd0;
      end
    end else if (psel && penable && pwrite && pready) begin
      alone_set[reg_idx] <= pwdata;
    end
  end

  stt_front u_front (
    .clk       (clk),
    .rst       (rst),
    .src_valid (src_valid),
    .src_stall (src_stall),
    .src_word  (src_word),
    .alone_map (alone_map),
    .full      (q_full),
    .push      (q_push),
    .job       (q_push_job)
  );

  stt_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (q_push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job)
  );

  stt_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .pop        (q_pop),
    .tok_valid  (tok_valid),
    .tok_stall  (tok_stall),
    .tok_word   (tok_word)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("job pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_head_valid) else $error("job popped from an empty queue");

  a_char_only_on_char: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.kind != stt_pkg::KIND_CHAR |-> tok_word.tok_char == 8'd0)
    else $error("character set on a non-character result");

  a_start_position: assert property (@(posedge clk) disable iff (rst)
    tok_valid && tok_word.kind == stt_pkg::KIND_START |->
      tok_word.line != 32'd0 && tok_word.column != 32'd0)
    else $error("token start with zero line or column");
`endif

endmodule
